[rtl/core/spjq_pkg.sv]
// Shared types, constants and codes of the stable priority job queue.
`default_nettype none
package spjq_pkg;

   localparam int PAGE_BITS    = 16;
   localparam int JOB_BITS     = 10;
   localparam int POS_BITS     = 7;
   localparam int OCC_BITS     = 7;
   localparam int CAPACITY_DEF = 64;

   // request kinds
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_BAD_POS   = 2'd3;

   typedef struct packed {
      logic [1:0]           kind;
      logic [PAGE_BITS-1:0] pages;
      logic [JOB_BITS-1:0]  job_id;
      logic [POS_BITS-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [JOB_BITS-1:0]  out_job;
      logic [PAGE_BITS-1:0] out_pages;
      logic [1:0]           status;
      logic [OCC_BITS-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] pages;
      logic [JOB_BITS-1:0]  job;
   } entry_type;

endpackage
`default_nettype wire

[rtl/core/stable_priority_job_queue_unit.sv]
// Top level of the stable priority job queue: sorted slot memory and its sequencer.
//
// Usage: a request item (insert, pop, delete at position) is taken at a clock edge
// with start high and busy low. Exactly one result item follows, shown for one
// cycle with rsp_strobe high; the receiver cannot stall and needs no handshake.
// Jobs sit in one slot memory in service order (slot 0 is the head), read through
// a registered output. Insert sinks the new job from the tail, moving one slot per
// cycle; pop and delete close the gap, one slot per cycle. The result waits for
// every slot move, the cost being set by the single read and write port of the
// slot memory. Rejected requests answer in the cycle after they are taken.
// Writing priority_mode over the APB port (byte address 0) re-sorts the held jobs
// by insertion sort through the same memory; busy stays high meanwhile. Equal
// page counts keep arrival order.
// Reset (synchronous, active high) empties the queue and selects min mode; the
// slot memory is not cleared, only slots below the job count are ever read.
`default_nettype none
module stable_priority_job_queue_unit #(
   parameter int CAPACITY = spjq_pkg::CAPACITY_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  spjq_pkg::req_type      req_data,
   output logic                   rsp_strobe,
   output spjq_pkg::rsp_type      rsp_data,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [2:0]             paddr,
   input  wire  [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SINK   = 3'd1;
   localparam logic [2:0] S_PUT    = 3'd2;
   localparam logic [2:0] S_RS_RD  = 3'd3;
   localparam logic [2:0] S_RS_GET = 3'd4;
   localparam logic [2:0] S_RM     = 3'd5;
   localparam logic [2:0] S_RM_WR  = 3'd6;
   localparam logic [2:0] S_POPGET = 3'd7;

   spjq_pkg::entry_type slot_mem_ff [CAPACITY];
   spjq_pkg::entry_type rd_q_ff;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   spjq_pkg::entry_type v_ff, v_in;
   spjq_pkg::entry_type pop_ff, pop_in;
   logic                ins_ff, ins_in;
   logic                mode_ff, mode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   spjq_pkg::rsp_type   rsp_ff, rsp_in;

   logic                rd_en, wr_en;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   spjq_pkg::entry_type wr_data;

   logic                accept, csr_wr, goes_first;
   logic [CNT_W-1:0]    km1, km2, kp1, kp2, ip1, im1, cntp1, cntm1;
   logic [31:0]         pos_ext, cnt_ext, posm1;

   assign accept = start && (state_ff == S_IDLE);
   assign csr_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign busy   = (state_ff != S_IDLE);

   assign km1   = k_ff - CNT_W'(1);
   assign km2   = k_ff - CNT_W'(2);
   assign kp1   = k_ff + CNT_W'(1);
   assign kp2   = k_ff + CNT_W'(2);
   assign ip1   = i_ff + CNT_W'(1);
   assign im1   = i_ff - CNT_W'(1);
   assign cntp1 = count_ff + CNT_W'(1);
   assign cntm1 = count_ff - CNT_W'(1);
   assign pos_ext = {{(32 - spjq_pkg::POS_BITS){1'b0}}, req_data.position};
   assign cnt_ext = 32'(count_ff);
   assign posm1   = pos_ext - 32'd1;

   // strict order test: ties never pass, which keeps arrival order
   assign goes_first = mode_ff ? (v_ff.pages > rd_q_ff.pages) : (v_ff.pages < rd_q_ff.pages);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      v_in         = v_ff;
      pop_in       = pop_ff;
      ins_in       = ins_ff;
      mode_in      = mode_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = v_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr) begin
               mode_in = pwdata[0];
               if (count_ff > CNT_W'(1)) begin
                  i_in     = CNT_W'(1);
                  ins_in   = 1'b0;
                  state_in = S_RS_RD;
               end
            end
            if (accept) begin
               rsp_in.out_job   = '0;
               rsp_in.out_pages = '0;
               rsp_in.status    = spjq_pkg::ST_DONE;
               rsp_in.occupancy = spjq_pkg::OCC_BITS'(count_ff);
               pop_in           = '0;
               v_in.pages       = req_data.pages;
               v_in.job         = req_data.job_id;
               ins_in           = 1'b1;
               priority case (req_data.kind)
                  spjq_pkg::KIND_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_in.status = spjq_pkg::ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == '0) begin
                        wr_en            = 1'b1;
                        wr_addr          = '0;
                        wr_data          = v_in;
                        count_in         = cntp1;
                        rsp_in.occupancy = spjq_pkg::OCC_BITS'(cntp1);
                        rsp_valid_in     = 1'b1;
                     end else begin
                        k_in     = count_ff;
                        rd_en    = 1'b1;
                        rd_addr  = cntm1[IDX_W-1:0];
                        state_in = S_SINK;
                     end
                  end
                  spjq_pkg::KIND_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = spjq_pkg::ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_POPGET;
                     end
                  end
                  spjq_pkg::KIND_DELETE: begin
                     if (pos_ext == 32'd0 || pos_ext > cnt_ext) begin
                        rsp_in.status = spjq_pkg::ST_BAD_POS;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        k_in     = CNT_W'(posm1);
                        state_in = S_RM;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SINK: begin
            wr_en   = 1'b1;
            wr_addr = k_ff[IDX_W-1:0];
            if (goes_first) begin
               // shift the compared entry down one slot and look further up
               wr_data = rd_q_ff;
               k_in    = km1;
               if (k_ff == CNT_W'(1)) begin
                  state_in = S_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = km2[IDX_W-1:0];
               end
            end else begin
               wr_data = v_ff;
               if (ins_ff) begin
                  count_in         = cntp1;
                  rsp_in.occupancy = spjq_pkg::OCC_BITS'(cntp1);
                  rsp_valid_in     = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  i_in     = ip1;
                  state_in = (ip1 < count_ff) ? S_RS_RD : S_IDLE;
               end
            end
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = v_ff;
            if (ins_ff) begin
               count_in         = cntp1;
               rsp_in.occupancy = spjq_pkg::OCC_BITS'(cntp1);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               i_in     = ip1;
               state_in = (ip1 < count_ff) ? S_RS_RD : S_IDLE;
            end
         end
         S_RS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = i_ff[IDX_W-1:0];
            state_in = S_RS_GET;
         end
         S_RS_GET: begin
            v_in     = rd_q_ff;
            k_in     = i_ff;
            rd_en    = 1'b1;
            rd_addr  = im1[IDX_W-1:0];
            state_in = S_SINK;
         end
         S_POPGET: begin
            pop_in   = rd_q_ff;
            k_in     = '0;
            state_in = S_RM;
         end
         S_RM: begin
            if (kp1 < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = kp1[IDX_W-1:0];
               state_in = S_RM_WR;
            end else begin
               count_in         = cntm1;
               rsp_in.out_job   = pop_ff.job;
               rsp_in.out_pages = pop_ff.pages;
               rsp_in.occupancy = spjq_pkg::OCC_BITS'(cntm1);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_RM_WR: begin
            // close the gap one slot per cycle
            wr_en   = 1'b1;
            wr_addr = k_ff[IDX_W-1:0];
            wr_data = rd_q_ff;
            k_in    = kp1;
            if (kp2 < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = kp2[IDX_W-1:0];
            end else begin
               count_in         = cntm1;
               rsp_in.out_job   = pop_ff.job;
               rsp_in.out_pages = pop_ff.pages;
               rsp_in.occupancy = spjq_pkg::OCC_BITS'(cntm1);
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= slot_mem_ff[rd_addr];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and loop registers
   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      i_ff   <= i_in;
      v_ff   <= v_in;
      pop_ff <= pop_in;
      ins_ff <= ins_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == 1'b0) ? {31'd0, mode_ff} : 32'd0;

`ifndef SYNTHESIS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while sequencer busy");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("job count above capacity");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == spjq_pkg::KIND_POP && count_ff == '0)
      |=> (rsp_strobe && rsp_data.status == spjq_pkg::ST_EMPTY))
      else $error("pop on empty queue not reported");
`endif

endmodule
`default_nettype wire

[verif/spjq_checker.sv]
// Checker for the stable priority job queue: queue prediction and result comparison.
`default_nettype none
module spjq_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire               busy,
   input  spjq_pkg::req_type req_data,
   input  wire               rsp_strobe,
   input  spjq_pkg::rsp_type rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [2:0]        paddr,
   input  wire  [31:0]       pwdata,
   input  wire               pready,
   output int                fail_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import spjq_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;

   // predicted queue contents in service order, index 0 is the head
   entry_type held_jobs[$];
   logic      mode_max;
   rsp_type   expected_rsps[$];

   function automatic bit served_first(logic [PAGE_BITS-1:0] a, logic [PAGE_BITS-1:0] b);
      return mode_max ? (a > b) : (a < b);
   endfunction

   // insert after every entry that does not strictly yield to the new one
   function automatic void sink_job(entry_type e);
      int k;
      k = held_jobs.size();
      while (k > 0 && served_first(e.pages, held_jobs[k-1].pages))
         k--;
      held_jobs.insert(k, e);
   endfunction

   // stable re-sort under the current mode
   function automatic void resort_jobs();
      entry_type old_jobs[$];
      old_jobs = held_jobs;
      held_jobs.delete();
      foreach (old_jobs[i])
         sink_job(old_jobs[i]);
   endfunction

   function automatic rsp_type predict_queue_op(req_type r);
      rsp_type   o;
      entry_type e;
      o = '0;
      case (r.kind)
         KIND_INSERT: begin
            if (held_jobs.size() >= CAPACITY)
               o.status = ST_FULL;
            else begin
               e.pages = r.pages;
               e.job   = r.job_id;
               sink_job(e);
            end
         end
         KIND_POP: begin
            if (held_jobs.size() == 0)
               o.status = ST_EMPTY;
            else begin
               e = held_jobs.pop_front();
               o.out_job   = e.job;
               o.out_pages = e.pages;
            end
         end
         KIND_DELETE: begin
            if (r.position == 0 || r.position > held_jobs.size())
               o.status = ST_BAD_POS;
            else
               held_jobs.delete(r.position - 1);
         end
         default: ;
      endcase
      o.occupancy = OCC_BITS'(held_jobs.size());
      return o;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held_jobs.delete();
         expected_rsps.delete();
         mode_max   = 1'b0;
         fail_count <= 0;
      end else begin
         // compare result first: a result never comes in the cycle of its own item
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result item %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected job %0d pages %0d status %0d occ %0d,",
                               " got job %0d pages %0d status %0d occ %0d"},
                              want.out_job, want.out_pages, want.status, want.occupancy,
                              rsp_data.out_job, rsp_data.out_pages, rsp_data.status,
                              rsp_data.occupancy);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy)
            expected_rsps.push_back(predict_queue_op(req_data));
         // mode register write
         if (psel && penable && pwrite && pready && paddr == 3'd0) begin
            mode_max = pwdata[0];
            resort_jobs();
         end
      end
   end
endmodule
`default_nettype wire

[verif/testbench.sv]
// Top of the job queue testbench: clock, reset, request and register stimulus, verdict.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spjq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count, pending_count;
   int          sender_idle_pct;
   int          occ_guess;

   always #5 clock = ~clock;

   stable_priority_job_queue_unit uut (.*);
   spjq_checker checker_i (.*);

   // present one request item and hold it until taken
   task automatic send_request(logic [1:0] k, logic [PAGE_BITS-1:0] p,
                               logic [JOB_BITS-1:0] j, logic [POS_BITS-1:0] pos);
      while ($urandom_range(99) < sender_idle_pct)
         @(negedge clock);
      req_data <= '{kind: k, pages: p, job_id: j, position: pos};
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      start <= 1'b0;
      @(negedge clock);
   endtask

   // let the queue drain, then write the mode register over APB
   task automatic write_mode(logic [31:0] v);
      while (pending_count != 0)
         @(negedge clock);
      repeat (5) @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      // wait out the re-sort
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // random request mix that keeps the queue moving between empty and full
   task automatic random_requests(int n, int fill_bias);
      int r;
      logic [PAGE_BITS-1:0] p;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         case ($urandom_range(3))
            0:       p = $urandom_range(3);
            1:       p = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: p = $urandom;
         endcase
         if (r < fill_bias) begin
            send_request(KIND_INSERT, p, $urandom, $urandom);
            if (occ_guess < 64) occ_guess++;
         end else if (r < fill_bias + 20) begin
            send_request(KIND_POP, $urandom, $urandom, $urandom);
            if (occ_guess > 0) occ_guess--;
         end else if (r < 98) begin
            send_request(KIND_DELETE, $urandom, $urandom,
                         $urandom_range(1) ? $urandom_range(occ_guess + 1) : $urandom);
         end else
            send_request(2'd3, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      sender_idle_pct = 0;
      occ_guess = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases, extremes, ties, every kind
      send_request(KIND_POP, '0, '0, '0);
      send_request(KIND_DELETE, '0, '0, 7'd1);
      send_request(KIND_INSERT, 16'hFFFF, 10'h3FF, 7'h7F);
      send_request(KIND_INSERT, 16'h0000, 10'h000, '0);
      send_request(KIND_INSERT, 16'd5, 10'd1, '0);
      send_request(KIND_INSERT, 16'd5, 10'd2, '0);
      send_request(KIND_INSERT, 16'd5, 10'd3, '0);
      send_request(KIND_DELETE, '0, '0, 7'd0);
      send_request(KIND_DELETE, '0, '0, 7'd6);
      send_request(KIND_DELETE, '0, '0, 7'h7F);
      send_request(2'd3, 16'hFFFF, 10'h3FF, 7'h7F);
      send_request(KIND_DELETE, '0, '0, 7'd5);
      send_request(KIND_POP, '0, '0, '0);
      send_request(KIND_DELETE, '0, '0, 7'd2);
      send_request(KIND_POP, '0, '0, '0);
      send_request(KIND_POP, '0, '0, '0);
      send_request(KIND_POP, '0, '0, '0);
      occ_guess = 0;

      // random phases with mode changes; the fill phase overflows the queue
      write_mode(32'hFFFF_FFFF);
      sender_idle_pct = 0;
      random_requests(300, 70);
      write_mode(32'd0);
      sender_idle_pct = 73;
      random_requests(300, 45);
      write_mode(32'hFFFF_FFFE);
      sender_idle_pct = 20;
      random_requests(300, 60);
      write_mode(32'd1);
      sender_idle_pct = 0;
      random_requests(300, 40);
      write_mode(32'd0);
      sender_idle_pct = 73;
      random_requests(300, 55);

      while (pending_count != 0)
         @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
